/* hdl/sgb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types and constants of the separable 5x5 blur unit.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int MIN_SIZE       = 5;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  localparam int CFG_W   = 12;   // configuration register width
  localparam int SZ_W    = 14;   // holds any frame size up to 8192
  localparam int POS_W   = 11;   // row and column fields of a result
  localparam int SUM_W   = 12;   // 1 2 4 2 1 sum of 8-bit values
  localparam int PROD_W  = 24;
  localparam int RECIP_W = 13;

  // q = (s * 6554) >> 16 equals s / 10 for every s below 2560
  localparam logic [RECIP_W-1:0] RECIP_10 = 13'd6554;
  localparam int RECIP_SHIFT = 16;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_STORE = 2'd0,   // line store update only
    JOB_VERT  = 2'd1,   // emits the vertical result of row r-2
    JOB_PASS  = 2'd2    // emits the horizontal result of row r
  } job_kind_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [7:0]       out_blue;
    logic [7:0]       out_green;
    logic [7:0]       out_red;
    logic             last_of_run;
    logic             frame_done;
  } out_pix_t;

endpackage
`default_nettype wire

/* hdl/sgb_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_stream_if
// Valid/ready stream carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface sgb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/separable_gaussian_blur_5x5_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// separable_gaussian_blur_5x5_unit
// Streaming 5x5 blur of BGR raster pixels as two 1 2 4 2 1 / 10 passes.
// ----------------------------------------------------------------------------
// Pixels enter on in_px in raster order; results leave on out_px, each with
// its own row and column, since border rows come out ahead of the filtered
// rows. cfg_we writes image_width (index 0) or image_height (index 1) and
// restarts the frame; write only while the unit is idle.
// Every input pixel expands into 0 to 6 jobs; one job issues per cycle, while
// the output queue has room, into a two-stage lane pipeline (horizontal tap
// with line store read, then vertical tap) and each emitting job pushes one
// result into an 8-entry output queue. Throughput: one pixel per cycle inside
// a row while the queue has room; the last pixel of a row also issues the jobs
// of the two right border columns and holds the input until they have issued,
// and in a last-two row at row 4 or later every pixel from column 2 on gives
// two results, one job each, which slows the input.
// Reset: size 640x480, counters and window cleared, queue empty. The line
// store is not cleared; it is always written before it is read.
// When out_px stalls, the queue fills, job issue stops and in_px.ready drops.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_5x5_unit
  import sgb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  sgb_stream_if.sink            in_px,
  sgb_stream_if.source          out_px,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam logic [SZ_W-1:0] MAXW = SZ_W'(MAX_WIDTH);
  localparam logic [SZ_W-1:0] MAXH = SZ_W'(MAX_HEIGHT);
  localparam logic [SZ_W-1:0] MINS = SZ_W'(MIN_SIZE);

  // configuration and position
  logic [CFG_W-1:0] width_r, height_r;
  logic [XW-1:0]    col_cnt_r;
  logic [YW-1:0]    row_cnt_r;
  logic [SZ_W-1:0]  size_w, size_h;
  pix_t             win_r [4];

  // item being expanded into jobs
  logic          item_vld_r;
  logic [2:0]    job_r;
  pix_t          it_px_r;
  pix_t          it_w_r [4];
  logic [XW-1:0] it_c0_r, it_wm2_r, it_wm1_r;
  logic          it_tap0_r, it_eor_r, it_vert_r, it_pass_r, it_done_r;
  logic [POS_W-1:0] it_row_r, it_rm2_r;

  // pipeline
  logic          s1_vld_r, s2_vld_r;
  job_kind_t     s1_kind_r, s2_kind_r;
  logic [XW-1:0] s1_col_r, s2_col_r;
  logic [POS_W-1:0] s1_row_r, s2_row_r;
  logic [1:0]    s1_bank_r;
  logic          s1_byp_r;
  pix_t          s1_bval_r;
  logic          s1_last_r, s2_last_r, s1_done_r, s2_done_r;
  pix_t          s2_hv_r;

  // output queue
  out_pix_t         fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  logic accept, issue, last_job, phase1, push, pop;
  logic [1:0] sel;
  logic [2:0] total_m1;
  job_kind_t  iss_kind;
  logic [XW-1:0] iss_col;
  logic       iss_byp;
  pix_t       iss_bval;
  logic [FIFO_AW+1:0] credit;

  logic [SZ_W-1:0] x_ext, y_ext;
  logic eor, vert, pass, done_px;

  pix_t q_h, q_v, hv;
  pix_t rd_data [4];
  pix_t vin [4];
  out_pix_t push_data;

  // ---------------- sizes and step flags ----------------
  always_comb begin
    if (SZ_W'(width_r) < MINS)      size_w = MINS;
    else if (SZ_W'(width_r) > MAXW) size_w = MAXW;
    else                            size_w = SZ_W'(width_r);
    if (SZ_W'(height_r) < MINS)      size_h = MINS;
    else if (SZ_W'(height_r) > MAXH) size_h = MAXH;
    else                             size_h = SZ_W'(height_r);
    x_ext   = SZ_W'(col_cnt_r);
    y_ext   = SZ_W'(row_cnt_r);
    eor     = (x_ext + SZ_W'(1)) >= size_w;
    vert    = row_cnt_r >= YW'(4);
    pass    = (row_cnt_r < YW'(2)) || ((y_ext + SZ_W'(2)) >= size_h);
    done_px = eor && ((y_ext + SZ_W'(1)) >= size_h);
  end

  // ---------------- job sequencing ----------------
  always_comb begin
    if (it_eor_r) total_m1 = (it_vert_r && it_pass_r) ? 3'd5 : 3'd2;
    else          total_m1 = (it_vert_r && it_pass_r) ? 3'd1 : 3'd0;
    phase1   = it_eor_r ? (job_r >= 3'd3) : (job_r >= 3'd1);
    if (phase1) sel = it_eor_r ? 2'(job_r - 3'd3) : 2'd0;
    else        sel = job_r[1:0];
    last_job = (job_r == total_m1);

    if (phase1 || (!it_vert_r && it_pass_r)) iss_kind = JOB_PASS;
    else if (it_vert_r)                      iss_kind = JOB_VERT;
    else                                     iss_kind = JOB_STORE;

    case (sel)
      2'd1: begin
        iss_col = it_wm2_r; iss_byp = 1'b1; iss_bval = it_w_r[0];
      end
      2'd2: begin
        iss_col = it_wm1_r; iss_byp = 1'b1; iss_bval = it_px_r;
      end
      default: begin
        iss_col = it_c0_r; iss_byp = !it_tap0_r; iss_bval = it_w_r[1];
      end
    endcase

    // jobs in flight reserve queue space so the pipeline never stalls
    credit = (FIFO_AW+2)'(cnt_r) + (FIFO_AW+2)'(s1_vld_r) + (FIFO_AW+2)'(s2_vld_r);
    issue  = item_vld_r && (credit < (FIFO_AW+2)'(FIFO_DEPTH));
  end

  assign in_px.ready = !item_vld_r || (issue && last_job);
  assign accept      = in_px.valid && in_px.ready;

  // ---------------- position, window, configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= CFG_W'(RST_WIDTH);
      height_r  <= CFG_W'(RST_HEIGHT);
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
      endcase
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      win_r[3] <= win_r[2];
      win_r[2] <= win_r[1];
      win_r[1] <= win_r[0];
      win_r[0] <= in_px.data;
      if (eor) begin
        col_cnt_r <= '0;
        row_cnt_r <= done_px ? '0 : row_cnt_r + YW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + XW'(1);
      end
    end
  end

  // ---------------- item register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      job_r      <= '0;
    end else if (accept) begin
      item_vld_r <= col_cnt_r >= XW'(2);   // columns 0 and 1 cause no job
      job_r      <= '0;
    end else if (issue) begin
      if (last_job) item_vld_r <= 1'b0;
      else          job_r      <= job_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_px_r   <= in_px.data;
      for (int i = 0; i < 4; i++) it_w_r[i] <= win_r[i];
      it_c0_r   <= col_cnt_r - XW'(2);
      it_wm2_r  <= XW'(size_w - SZ_W'(2));
      it_wm1_r  <= XW'(size_w - SZ_W'(1));
      it_tap0_r <= col_cnt_r >= XW'(4);
      it_eor_r  <= eor;
      it_vert_r <= vert;
      it_pass_r <= pass;
      it_done_r <= done_px;
      it_row_r  <= POS_W'(row_cnt_r);
      it_rm2_r  <= POS_W'(row_cnt_r - YW'(2));
    end
  end

  // ---------------- horizontal lanes and line store ----------------
  sgb_tap3 u_htap (
    .clk(clk), .a(it_w_r[3]), .b(it_w_r[2]), .c(it_w_r[1]), .d(it_w_r[0]), .e(it_px_r),
    .q(q_h)
  );

  assign hv = s1_byp_r ? s1_bval_r : q_h;

  sgb_line_store #(
    .MAX_WIDTH(MAX_WIDTH), .AW(XW)
  ) u_store (
    .clk(clk), .rd_addr(iss_col), .wr_en(s1_vld_r), .wr_bank(s1_bank_r),
    .wr_addr(s1_col_r), .wr_data(hv), .rd_data(rd_data)
  );

  // bank of row r-4 is r mod 4, the newer rows follow it
  always_comb begin
    for (int k = 0; k < 4; k++) vin[k] = rd_data[2'(s1_bank_r + 2'(k))];
  end

  sgb_tap3 u_vtap (
    .clk(clk), .a(vin[0]), .b(vin[1]), .c(vin[2]), .d(vin[3]), .e(hv), .q(q_v)
  );

  // ---------------- pipeline stages ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= iss_kind;
    s1_col_r  <= iss_col;
    s1_row_r  <= (iss_kind == JOB_VERT) ? it_rm2_r : it_row_r;
    s1_bank_r <= it_row_r[1:0];
    s1_byp_r  <= iss_byp;
    s1_bval_r <= iss_bval;
    s1_last_r <= last_job;
    s1_done_r <= last_job && it_done_r;
    s2_kind_r <= s1_kind_r;
    s2_col_r  <= s1_col_r;
    s2_row_r  <= s1_row_r;
    s2_hv_r   <= hv;
    s2_last_r <= s1_last_r;
    s2_done_r <= s1_done_r;
  end

  // ---------------- output queue ----------------
  always_comb begin
    pix_t v;
    v = (s2_kind_r == JOB_VERT) ? q_v : s2_hv_r;
    push_data.out_row     = s2_row_r;
    push_data.out_col     = POS_W'(s2_col_r);
    push_data.out_blue    = v.blue;
    push_data.out_green   = v.green;
    push_data.out_red     = v.red;
    push_data.last_of_run = s2_last_r;
    push_data.frame_done  = s2_done_r;
  end

  assign push = s2_vld_r && (s2_kind_r != JOB_STORE);
  assign pop  = out_px.valid && out_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= push_data;
  end

  assign out_px.valid = cnt_r != '0;
  assign out_px.data  = fifo_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("output queue overflow");

  a_job_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r |-> (job_r <= total_m1))
    else $error("job counter past end of item");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.frame_done) |-> push_data.last_of_run)
    else $error("frame_done on a result that is not last of its run");

  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && (s1_kind_r == JOB_STORE)) |=> !push)
    else $error("store-only job produced a result");
`endif

endmodule
`default_nettype wire

/* hdl/sgb_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_lane
// One color lane: 1 2 4 2 1 weighted sum, divided by 10 (truncating).
// ----------------------------------------------------------------------------
module sgb_lane
  import sgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [7:0] c,
  input  wire logic [7:0] d,
  input  wire logic [7:0] e,
  output logic [7:0]      q
);

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;

  always_comb begin
    sum = {4'b0, a} + {3'b0, b, 1'b0} + {2'b0, c, 2'b0} + {3'b0, d, 1'b0} + {4'b0, e};
    prod_nxt = {{(PROD_W-SUM_W){1'b0}}, sum} * {{(PROD_W-RECIP_W){1'b0}}, RECIP_10};
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // reciprocal multiply, registered product
  assign q = prod_r[RECIP_SHIFT +: 8];

endmodule
`default_nettype wire

/* hdl/sgb_tap3.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_tap3
// Three color lanes side by side, merged back into one pixel.
// ----------------------------------------------------------------------------
module sgb_tap3
  import sgb_pkg::*;
(
  input  wire logic clk,
  input  wire pix_t a,
  input  wire pix_t b,
  input  wire pix_t c,
  input  wire pix_t d,
  input  wire pix_t e,
  output pix_t      q
);

  logic [7:0] q_b;
  logic [7:0] q_g;
  logic [7:0] q_r;

  sgb_lane u_lane_b (
    .clk(clk), .a(a.blue), .b(b.blue), .c(c.blue), .d(d.blue), .e(e.blue), .q(q_b)
  );
  sgb_lane u_lane_g (
    .clk(clk), .a(a.green), .b(b.green), .c(c.green), .d(d.green), .e(e.green), .q(q_g)
  );
  sgb_lane u_lane_r (
    .clk(clk), .a(a.red), .b(b.red), .c(c.red), .d(d.red), .e(e.red), .q(q_r)
  );

  always_comb begin
    q.blue  = q_b;
    q.green = q_g;
    q.red   = q_r;
  end

endmodule
`default_nettype wire

/* hdl/sgb_line_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_line_store
// Four banks of horizontal results, bank = row mod 4, address = column.
// ----------------------------------------------------------------------------
module sgb_line_store
  import sgb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_bank,
  input  wire logic [AW-1:0] wr_addr,
  input  wire pix_t          wr_data,
  output pix_t               rd_data [4]
);

  for (genvar g = 0; g < 4; g++) begin : g_bank
    pix_t mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(g))) begin
        mem[wr_addr] <= wr_data;
      end
      rd_data[g] <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* dv/separable_gaussian_blur_5x5_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_gaussian_blur_5x5_unit_tb
// Streams BGR frames through the blur unit and predicts every result in the
// bench. Each result is checked by position, value, last_of_run and frame_done
// against the oldest prediction. Frame sizes are swept, including the saturated
// extremes. Sender bursts and receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_5x5_unit_tb;
  import sgb_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYC  = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  sgb_stream_if #(.T(pix_t)) in_if ();
  sgb_stream_if #(.T(out_pix_t)) out_if ();

  separable_gaussian_blur_5x5_unit dut (
    .clk(clk), .rst_n(rst_n), .in_px(in_if.sink), .out_px(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // blur state mirrored in the bench
  pix_t pix_hist [4];
  pix_t hline [4][MAX_WIDTH_DEF];
  int unsigned cur_row, cur_col;
  logic [CFG_W-1:0] width_reg, height_reg;
  out_pix_t blurred_q[$];

  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int hold_off = 0;
  int stall_mode = 0;
  int mode_cnt = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  function automatic pix_t tap5(pix_t a, pix_t b, pix_t c, pix_t d, pix_t e);
    pix_t r;
    r.blue  = 8'((a.blue + 2 * b.blue + 4 * c.blue + 2 * d.blue + e.blue) / 10);
    r.green = 8'((a.green + 2 * b.green + 4 * c.green + 2 * d.green + e.green) / 10);
    r.red   = 8'((a.red + 2 * b.red + 4 * c.red + 2 * d.red + e.red) / 10);
    return r;
  endfunction

  function automatic out_pix_t mk_out(int unsigned row, int unsigned col, pix_t p);
    out_pix_t o;
    o.out_row = POS_W'(row);
    o.out_col = POS_W'(col);
    o.out_blue = p.blue;
    o.out_green = p.green;
    o.out_red = p.red;
    o.last_of_run = 1'b0;
    o.frame_done = 1'b0;
    return o;
  endfunction

  // predicts the results caused by one accepted pixel
  task automatic blur_step(input pix_t px);
    int unsigned w, h, x, r, n;
    int unsigned cols [3];
    pix_t hv [3];
    out_pix_t res [$];
    out_pix_t o;
    logic done;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    x = cur_col;
    r = cur_row;
    n = 0;
    done = 1'b0;
    if (x >= 2) begin
      cols[n] = x - 2;
      if (x - 2 >= 2 && x + 1 <= w)
        hv[n] = tap5(pix_hist[3], pix_hist[2], pix_hist[1], pix_hist[0], px);
      else
        hv[n] = pix_hist[1];
      n++;
    end
    if (x + 1 >= w) begin
      cols[n] = w - 2; hv[n] = pix_hist[0]; n++;
      cols[n] = w - 1; hv[n] = px; n++;
    end
    if (r >= 4) begin
      for (int i = 0; i < n; i++)
        res.push_back(mk_out(r - 2, cols[i], tap5(hline[(r - 4) & 3][cols[i]],
          hline[(r - 3) & 3][cols[i]], hline[(r - 2) & 3][cols[i]],
          hline[(r - 1) & 3][cols[i]], hv[i])));
    end
    if (r < 2 || r + 2 >= h) begin
      for (int i = 0; i < n; i++) res.push_back(mk_out(r, cols[i], hv[i]));
    end
    for (int i = 0; i < n; i++) hline[r & 3][cols[i]] = hv[i];
    pix_hist[3] = pix_hist[2];
    pix_hist[2] = pix_hist[1];
    pix_hist[1] = pix_hist[0];
    pix_hist[0] = px;
    if (x + 1 >= w) begin
      cur_col = 0;
      if (r + 1 >= h) begin
        cur_row = 0;
        done = 1'b1;
      end else begin
        cur_row = r + 1;
      end
    end else begin
      cur_col = x + 1;
    end
    if (res.size() > 0) begin
      o = res[$];
      o.last_of_run = 1'b1;
      o.frame_done = done;
      res[$] = o;
    end
    foreach (res[i]) blurred_q.push_back(res[i]);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_pix_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (blurred_q.size() == 0) begin
        report("unexpected result row", got.out_row, -1);
      end else begin
        want = blurred_q.pop_front();
        if (got.out_row != want.out_row) report("out_row", got.out_row, want.out_row);
        if (got.out_col != want.out_col) report("out_col", got.out_col, want.out_col);
        if (got.out_blue != want.out_blue) report("out_blue", got.out_blue, want.out_blue);
        if (got.out_green != want.out_green)
          report("out_green", got.out_green, want.out_green);
        if (got.out_red != want.out_red) report("out_red", got.out_red, want.out_red);
        if (got.last_of_run != want.last_of_run)
          report("last_of_run", got.last_of_run, want.last_of_run);
        if (got.frame_done != want.frame_done)
          report("frame_done", got.frame_done, want.frame_done);
      end
    end
  end

  // receiver stall pattern, plus explicit hold-off stretches
  always @(posedge clk) begin
    mode_cnt <= mode_cnt + 1;
    if (mode_cnt % 150 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_if.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 9) > 3);
        default: out_if.ready <= (mode_cnt % 5 != 2);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_px(input pix_t p);
    logic rdy;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data <= p;
    forever begin
      @(negedge clk);
      rdy = in_if.ready;
      @(posedge clk);
      if (rdy) break;
    end
    blur_step(p);
  endtask

  function automatic pix_t rand_px();
    return pix_t'(24'($urandom_range(0, 24'hFFFFFF)));
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = CFG_W'(val);
    else height_reg = CFG_W'(val);
    cur_row = 0;
    cur_col = 0;
    @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h);
    for (int i = 0; i < w * h; i++) send_px(rand_px());
  endtask

  // reset size is 640x480: a part of row 0 must come straight back
  task automatic test_reset_size();
    for (int i = 0; i < 8; i++) send_px(rand_px());
  endtask

  // sizes below the minimum give a 5x5 frame with field extremes,
  // then a frame that a later size write cuts short
  task automatic test_directed();
    pix_t p;
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 4);
    for (int i = 0; i < 25; i++) begin
      case (i % 4)
        0: p = 24'hFFFFFF;
        1: p = 24'h000000;
        2: p = {8'hFF, 8'h00, 8'hFF};
        default: p = rand_px();
      endcase
      send_px(p);
    end
    for (int i = 0; i < 6; i++) send_px(24'hFFFFFF);
  endtask

  // sizes above the maximum saturate
  task automatic test_size_extremes();
    write_reg(CFG_IMAGE_WIDTH, 4095);
    write_reg(CFG_IMAGE_HEIGHT, 5);
    for (int i = 0; i < 8; i++) send_px(rand_px());
    write_reg(CFG_IMAGE_WIDTH, 5);
    write_reg(CFG_IMAGE_HEIGHT, 4095);
    for (int i = 0; i < 12; i++) send_px(rand_px());
  endtask

  // random small frame, then a frame cut short by the next size write
  task automatic test_random_frames();
    int unsigned w, h, n;
    w = $urandom_range(5, 6);
    h = $urandom_range(5, 6);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
    end else begin
      write_reg(CFG_IMAGE_HEIGHT, h);
      write_reg(CFG_IMAGE_WIDTH, w);
    end
    send_frame(w, h);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send_px(rand_px());
  endtask

  // long receiver hold-off while pixels keep coming
  task automatic test_backpressure();
    write_reg(CFG_IMAGE_WIDTH, 5);
    write_reg(CFG_IMAGE_HEIGHT, 5);
    hold_off = 400;
    burst_left = 1000;
    send_frame(5, 5);
    burst_left = 0;
  endtask

  initial begin
    width_reg = CFG_W'(RST_WIDTH);
    height_reg = CFG_W'(RST_HEIGHT);
    cur_row = 0;
    cur_col = 0;
    foreach (pix_hist[i]) pix_hist[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_directed();
    test_size_extremes();
    test_random_frames();
    test_backpressure();
    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* separable_gaussian_blur_5x5_unit.f */
hdl/sgb_pkg.sv
hdl/sgb_stream_if.sv
hdl/sgb_lane.sv
hdl/sgb_tap3.sv
hdl/sgb_line_store.sv
hdl/separable_gaussian_blur_5x5_unit.sv
dv/separable_gaussian_blur_5x5_unit_tb.sv
